/* hw/rtl/pufwl_pkg.sv */
package pufwl_pkg;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	localparam logic [1:0] REG_ENABLED = 2'd0;
	localparam logic [1:0] REG_WINDOW  = 2'd1;
	localparam logic [1:0] REG_LIMIT   = 2'd2;

	typedef enum logic [1:0] {
		KIND_COUNT,
		KIND_PASS,
		KIND_START
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  slot;
		logic [31:0] now_seconds;
	} entry_t;

	typedef struct packed {
		logic        enabled;
		logic [15:0] window_seconds;
		logic [15:0] line_limit;
	} cfg_t;

	typedef enum logic {
		BK_IDLE,
		BK_CALC
	} back_state_t;

endpackage

/* hw/rtl/pufwl_msg_if.sv */
interface pufwl_msg_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [7:0]  user_index;
	logic        exempt;
	logic [31:0] now_seconds;

	modport source (output valid, output operation, output user_index, output exempt,
		output now_seconds, input ready);
	modport sink (input valid, input operation, input user_index, input exempt,
		input now_seconds, output ready);
endinterface

/* hw/rtl/pufwl_verdict_if.sv */
interface pufwl_verdict_if;
	logic        valid;
	logic        ready;
	logic        deny;
	logic [15:0] user_count;

	modport source (output valid, output deny, output user_count, input ready);
	modport sink (input valid, input deny, input user_count, output ready);
endinterface

/* hw/rtl/per_user_fixed_window_limiter.sv */
// A start or pass-through item reaches the output through a two-entry queue and the output
// register; a counted message also goes through the registered read of the counter memory.
// Throughput: one start or pass-through item per cycle while the verdict output is not
// stalled; a counted message blocks the next item until its counter read and write finish.
// Reset (arst_n low, asynchronous) empties the queue and output, clears the deadline and all
// counter valid bits at once, and sets enabled 0, window_seconds 1, line_limit 2.
module per_user_fixed_window_limiter #(
	parameter int unsigned USER_SLOTS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	pufwl_msg_if.sink         msg,
	pufwl_verdict_if.source   verdict
);
	import pufwl_pkg::*;

	localparam int unsigned DEPTH = (USER_SLOTS < 256) ? USER_SLOTS : 256;

	cfg_t   cfg_q;
	logic   cfg_write;
	logic   push_valid;
	logic   push_ready;
	entry_t push_entry;
	logic   pop_valid;
	logic   pop;
	entry_t pop_entry;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled <= 1'b0;
			cfg_q.window_seconds <= 16'd1;
			cfg_q.line_limit <= 16'd2;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_ENABLED: cfg_q.enabled <= pwdata[0];
				REG_WINDOW: cfg_q.window_seconds <= pwdata[15:0];
				REG_LIMIT: cfg_q.line_limit <= pwdata[15:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ENABLED: prdata = {31'd0, cfg_q.enabled};
			REG_WINDOW: prdata = {16'd0, cfg_q.window_seconds};
			REG_LIMIT: prdata = {16'd0, cfg_q.line_limit};
			default: prdata = 32'd0;
		endcase
	end

	pufwl_front #(
		.DEPTH(DEPTH)
	) u_front (
		.msg       (msg),
		.enabled   (cfg_q.enabled),
		.push_ready(push_ready),
		.push_valid(push_valid),
		.push_entry(push_entry)
	);

	pufwl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_entry (pop_entry)
	);

	pufwl_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_valid(pop_valid),
		.q_entry(pop_entry),
		.q_pop  (pop),
		.verdict(verdict)
	);
endmodule

/* hw/rtl/pufwl_ram.sv */
module pufwl_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* hw/rtl/pufwl_front.sv */
module pufwl_front #(
	parameter int unsigned DEPTH = 256
) (
	pufwl_msg_if.sink         msg,
	input  logic              enabled,
	input  logic              push_ready,
	output logic              push_valid,
	output pufwl_pkg::entry_t push_entry
);
	import pufwl_pkg::*;

	typedef logic [255:0][7:0] slot_lut_t;

	function automatic slot_lut_t build_slot_lut();
		slot_lut_t lut;
		for (int i = 0; i < 256; i++) begin
			lut[i] = 8'(i % DEPTH);
		end
		return lut;
	endfunction

	localparam slot_lut_t SLOT_LUT = build_slot_lut();

	logic [7:0] slot;

	assign slot = SLOT_LUT[msg.user_index];

	always_comb begin
		if (msg.operation) begin
			push_entry.kind = KIND_START;
		end else if (msg.exempt || !enabled) begin
			push_entry.kind = KIND_PASS;
		end else begin
			push_entry.kind = KIND_COUNT;
		end
		push_entry.slot = slot;
		push_entry.now_seconds = msg.now_seconds;
	end

	assign push_valid = msg.valid;
	assign msg.ready = push_ready;
endmodule

/* hw/rtl/pufwl_queue.sv */
module pufwl_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  pufwl_pkg::entry_t push_entry,
	output logic              pop_valid,
	input  logic              pop,
	output pufwl_pkg::entry_t pop_entry
);
	import pufwl_pkg::*;

	localparam int unsigned SLOTS = 2;

	entry_t     entry_q [SLOTS];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'(SLOTS));
	assign pop_valid = (count_q != 2'd0);
	assign pop_entry = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

/* hw/rtl/pufwl_back.sv */
module pufwl_back #(
	parameter int unsigned DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pufwl_pkg::cfg_t   cfg,
	input  logic              q_valid,
	input  pufwl_pkg::entry_t q_entry,
	output logic              q_pop,
	pufwl_verdict_if.source   verdict
);
	import pufwl_pkg::*;

	localparam int unsigned SLOT_W = $clog2(DEPTH);

	back_state_t       state_q;
	back_state_t       state_d;
	logic [SLOT_W-1:0] slot_q;
	logic [31:0]       now_q;
	logic [32:0]       deadline_q;
	logic [32:0]       deadline_d;
	logic [DEPTH-1:0]  valid_q;
	logic [DEPTH-1:0]  valid_d;
	logic              out_valid_q;
	logic              deny_q;
	logic [15:0]       count_q;
	logic              deny_d;
	logic [15:0]       count_d;
	logic              out_free;
	logic              out_load;
	logic              ram_re;
	logic              ram_we;
	logic [15:0]       ram_rdata;
	logic              rollover;
	logic [15:0]       old_count;
	logic [15:0]       new_count;

	pufwl_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_counts (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_q),
		.wdata(new_count),
		.re   (ram_re),
		.raddr(q_entry.slot[SLOT_W-1:0]),
		.rdata(ram_rdata)
	);

	assign out_free = !out_valid_q || verdict.ready;
	assign rollover = {1'b0, now_q} > deadline_q;
	assign old_count = (rollover || !valid_q[slot_q]) ? 16'd0 : ram_rdata;
	assign new_count = (old_count == COUNT_MAX) ? old_count : old_count + 16'd1;

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		ram_re = 1'b0;
		ram_we = 1'b0;
		valid_d = valid_q;
		deadline_d = deadline_q;
		out_load = 1'b0;
		deny_d = 1'b0;
		count_d = 16'd0;
		case (state_q)
			BK_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					case (q_entry.kind)
						KIND_START: begin
							valid_d = '0;
							deadline_d = {1'b0, q_entry.now_seconds} + {17'd0, cfg.window_seconds};
							out_load = 1'b1;
						end
						KIND_PASS: begin
							out_load = 1'b1;
						end
						KIND_COUNT: begin
							ram_re = 1'b1;
							state_d = BK_CALC;
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			BK_CALC: begin
				ram_we = 1'b1;
				if (rollover) begin
					valid_d = '0;
					deadline_d = {1'b0, now_q} + {17'd0, cfg.window_seconds};
				end
				valid_d[slot_q] = 1'b1;
				out_load = 1'b1;
				deny_d = (new_count >= cfg.line_limit);
				count_d = new_count;
				state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			deadline_q <= '0;
			valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			deadline_q <= deadline_d;
			valid_q <= valid_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (verdict.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			slot_q <= q_entry.slot[SLOT_W-1:0];
			now_q <= q_entry.now_seconds;
		end
		if (out_load) begin
			deny_q <= deny_d;
			count_q <= count_d;
		end
	end

	assign verdict.valid = out_valid_q;
	assign verdict.deny = deny_q;
	assign verdict.user_count = count_q;

`ifndef SYNTHESIS
	a_calc_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_CALC |=> state_q == BK_IDLE)
		else $error("counter update held for more than one cycle");
	a_calc_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_CALC |-> $past(ram_re))
		else $error("counter update without a preceding table read");
	a_calc_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_CALC |-> !out_valid_q)
		else $error("counter update while the output register is occupied");
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> new_count != 16'd0)
		else $error("a counted message wrote a zero count");
`endif
endmodule
